// File: sv/memb_pkg.sv
// shared types and constants for the multi-endpoint mailbox
package memb_pkg;

   localparam int EP_BITS   = 8;
   localparam int DATA_BITS = 32;
   localparam int PEND_BITS = 5;
   localparam int CFG_BITS  = 5;
   // the active count register is 5 bits wide, so no id above this can ever be live
   localparam int EP_LIMIT  = 31;

   typedef enum logic [0:0] {
      FUNC_SEND = 1'b0,
      FUNC_RECV = 1'b1
   } func_type;

   typedef enum logic [1:0] {
      ST_OK      = 2'd0,
      ST_INVALID = 2'd1,
      ST_FULL    = 2'd2,
      ST_EMPTY   = 2'd3
   } status_type;

   typedef struct packed {
      logic load;
      logic exec;
      logic fetch;
   } cmd_type;

endpackage

// File: sv/memb_ram.sv
// generic single-clock ram, one write port and one registered read port
module memb_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 256
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem_ff[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

// File: sv/memb_ctrl.sv
// controller state machine: accept, execute, fetch read data, present result
module memb_ctrl (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  logic               rsp_tready,
   output memb_pkg::cmd_type  cmd
);

   typedef enum logic [3:0] {
      S_IDLE  = 4'b0001,
      S_EXEC  = 4'b0010,
      S_FETCH = 4'b0100,
      S_SEND  = 4'b1000
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) state_in = S_EXEC;
         end
         S_EXEC:  state_in = S_FETCH;
         S_FETCH: state_in = S_SEND;
         S_SEND: begin
            if (rsp_tready) state_in = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = (state_ff == S_SEND);
   assign cmd.load   = (state_ff == S_IDLE) && req_tvalid;
   assign cmd.exec   = (state_ff == S_EXEC);
   assign cmd.fetch  = (state_ff == S_FETCH);

endmodule

// File: sv/memb_datapath.sv
// datapath: per-endpoint pointers and counts, message store, result register
module memb_datapath #(
   parameter int MAX_ENDPOINTS = 16,
   parameter int QUEUE_DEPTH   = 16,
   parameter int MSG_BITS      = 32
) (
   input  logic                           clock,
   input  logic                           reset,
   input  memb_pkg::cmd_type              cmd,
   input  logic                           req_func,
   input  logic [memb_pkg::EP_BITS-1:0]   req_endpoint,
   input  logic [memb_pkg::DATA_BITS-1:0] req_message,
   input  logic                           csr_we,
   input  logic [memb_pkg::CFG_BITS-1:0]  csr_value,
   output memb_pkg::status_type           rsp_status,
   output logic [memb_pkg::DATA_BITS-1:0] rsp_received,
   output logic [memb_pkg::PEND_BITS-1:0] rsp_pending,
   output logic                           rsp_has_messages
);

   localparam int NumEp     = (MAX_ENDPOINTS < memb_pkg::EP_LIMIT) ? MAX_ENDPOINTS
                                                                   : memb_pkg::EP_LIMIT;
   localparam int IdxBits   = (NumEp > 1) ? $clog2(NumEp) : 1;
   localparam int PtrBits   = $clog2(QUEUE_DEPTH);
   localparam int CntBits   = $clog2(QUEUE_DEPTH + 1);
   localparam int StoreBits = (MSG_BITS < memb_pkg::DATA_BITS) ? MSG_BITS
                                                               : memb_pkg::DATA_BITS;
   localparam int Depth     = NumEp * QUEUE_DEPTH;
   localparam int AddrBits  = $clog2(Depth);
   localparam logic [memb_pkg::CFG_BITS-1:0] NumEpCnt = memb_pkg::CFG_BITS'(NumEp);

   // configuration
   logic [memb_pkg::CFG_BITS-1:0] active_ff;
   logic [memb_pkg::CFG_BITS-1:0] old_eff, new_eff, cur_eff;

   // per-endpoint queue state
   logic [PtrBits-1:0] rdptr_ff [NumEp];
   logic [PtrBits-1:0] wrptr_ff [NumEp];
   logic [CntBits-1:0] count_ff [NumEp];

   // latched item
   logic                           func_ff;
   logic [memb_pkg::EP_BITS-1:0]   ep_ff;
   logic [StoreBits-1:0]           msg_ff;

   // result
   memb_pkg::status_type           status_ff, status_in;
   logic [CntBits-1:0]             pend_ff, pend_in;
   logic                           has_ff, has_in;
   logic                           take_ff, take_in;
   logic [memb_pkg::DATA_BITS-1:0] recv_ff;

   logic [IdxBits-1:0]  idx;
   logic                ep_valid;
   logic [CntBits-1:0]  cur_cnt, new_cnt;
   logic [PtrBits-1:0]  cur_rd, cur_wr, nxt_rd, nxt_wr;
   logic                do_write, do_read;
   logic [AddrBits-1:0] base, wr_addr, rd_addr;
   logic [StoreBits-1:0] rd_data;

   function automatic logic [memb_pkg::CFG_BITS-1:0] eff_count(
      input logic [memb_pkg::CFG_BITS-1:0] v
   );
      eff_count = (v > NumEpCnt) ? NumEpCnt : v;
   endfunction

   function automatic logic [PtrBits-1:0] advance(input logic [PtrBits-1:0] p);
      advance = (p == PtrBits'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
   endfunction

   assign old_eff  = eff_count(active_ff);
   assign new_eff  = eff_count(csr_value);
   assign cur_eff  = old_eff;
   assign ep_valid = ep_ff < {{(memb_pkg::EP_BITS - memb_pkg::CFG_BITS){1'b0}}, cur_eff};
   assign idx      = ep_ff[IdxBits-1:0];
   assign cur_cnt  = count_ff[idx];
   assign cur_rd   = rdptr_ff[idx];
   assign cur_wr   = wrptr_ff[idx];
   assign nxt_rd   = advance(cur_rd);
   assign nxt_wr   = advance(cur_wr);

   always_comb begin
      status_in = memb_pkg::ST_OK;
      new_cnt   = cur_cnt;
      if (!ep_valid) begin
         status_in = memb_pkg::ST_INVALID;
      end else if (func_ff == memb_pkg::FUNC_SEND) begin
         if (cur_cnt == CntBits'(QUEUE_DEPTH)) begin
            status_in = memb_pkg::ST_FULL;
         end else begin
            new_cnt = cur_cnt + 1'b1;
         end
      end else begin
         if (cur_cnt == '0) begin
            status_in = memb_pkg::ST_EMPTY;
         end else begin
            new_cnt = cur_cnt - 1'b1;
         end
      end
      pend_in  = ep_valid ? new_cnt : '0;
      has_in   = ep_valid && (new_cnt != '0);
      do_write = cmd.exec && (status_in == memb_pkg::ST_OK) && (func_ff == memb_pkg::FUNC_SEND);
      do_read  = cmd.exec && (status_in == memb_pkg::ST_OK) && (func_ff == memb_pkg::FUNC_RECV);
      take_in  = do_read;
   end

   assign base    = AddrBits'(idx) * AddrBits'(QUEUE_DEPTH);
   assign wr_addr = base + AddrBits'(cur_wr);
   assign rd_addr = base + AddrBits'(cur_rd);

   memb_ram #(
      .WIDTH (StoreBits),
      .DEPTH (Depth)
   ) u_store (
      .clock   (clock),
      .wr_en   (do_write),
      .wr_addr (wr_addr),
      .wr_data (msg_ff),
      .rd_en   (do_read),
      .rd_addr (rd_addr),
      .rd_data (rd_data)
   );

   // queue state; creating endpoints clears their pointers and counts
   always_ff @(posedge clock) begin
      if (reset) begin
         active_ff <= '0;
         for (int i = 0; i < NumEp; i++) begin
            rdptr_ff[i] <= '0;
            wrptr_ff[i] <= '0;
            count_ff[i] <= '0;
         end
      end else if (csr_we) begin
         active_ff <= csr_value;
         for (int i = 0; i < NumEp; i++) begin
            if ((memb_pkg::CFG_BITS'(i) >= old_eff) && (memb_pkg::CFG_BITS'(i) < new_eff)) begin
               rdptr_ff[i] <= '0;
               wrptr_ff[i] <= '0;
               count_ff[i] <= '0;
            end
         end
      end else if (cmd.exec && (status_in == memb_pkg::ST_OK)) begin
         count_ff[idx] <= new_cnt;
         if (func_ff == memb_pkg::FUNC_SEND) begin
            wrptr_ff[idx] <= nxt_wr;
         end else begin
            rdptr_ff[idx] <= nxt_rd;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         func_ff <= req_func;
         ep_ff   <= req_endpoint;
         msg_ff  <= req_message[StoreBits-1:0];
      end
      if (cmd.exec) begin
         status_ff <= status_in;
         pend_ff   <= pend_in;
         has_ff    <= has_in;
         take_ff   <= take_in;
      end
      if (cmd.fetch) begin
         recv_ff <= take_ff ? memb_pkg::DATA_BITS'(rd_data) : '0;
      end
   end

   assign rsp_status       = status_ff;
   assign rsp_received     = recv_ff;
   assign rsp_pending      = memb_pkg::PEND_BITS'(pend_ff);
   assign rsp_has_messages = has_ff;

endmodule

// File: sv/multi_endpoint_mailbox.sv
// top level of the multi-endpoint mailbox
//
// A bank of fifo mailboxes, one per endpoint. Each request item on the req_
// channel is a send (tuser 0) or a receive (tuser 1) aimed at one endpoint;
// each one gives exactly one response item on the rsp_ channel carrying a
// status in tuser and the received word, pending count and has-messages flag
// in tdata. The csr_ channel writes the active endpoint count; endpoints at or
// above it (or at or above the build limit) get an invalid status. Raising
// the count clears the queues of the newly created endpoints.
// One item is handled at a time: req_tready is high only while idle. The item
// is latched at the accepting edge, the next cycle looks up and updates the
// endpoint state and issues the message store access, the one after that takes
// the registered store read, and rsp_tvalid rises with that registered result.
// A new item is accepted only once the response has been taken and the block
// is back in idle. A stalled receiver holds the response and the block takes no
// new item until it is taken. Reset empties all queues and sets the active
// count to zero; no clearing pass is needed. The configuration port is always
// ready; the user must see that it is written only while no item is in flight,
// as the block itself does not enforce this.
module multi_endpoint_mailbox #(
   parameter int MAX_ENDPOINTS = 16,
   parameter int QUEUE_DEPTH   = 16,
   parameter int MSG_BITS      = 32
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [39:0] req_tdata,   // endpoint[7:0], message[39:8]
   input  logic [0:0]  req_tuser,   // func
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,   // received[31:0], pending[36:32], has_messages[37], zero
   output logic [1:0]  rsp_tuser,   // status
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [4:0]  csr_data     // active_endpoints
);

   memb_pkg::cmd_type              cmd;
   memb_pkg::status_type           status;
   logic [memb_pkg::DATA_BITS-1:0] received;
   logic [memb_pkg::PEND_BITS-1:0] pending;
   logic                           has_messages;

   memb_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .cmd        (cmd)
   );

   memb_datapath #(
      .MAX_ENDPOINTS (MAX_ENDPOINTS),
      .QUEUE_DEPTH   (QUEUE_DEPTH),
      .MSG_BITS      (MSG_BITS)
   ) u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .req_func         (req_tuser[0]),
      .req_endpoint     (req_tdata[7:0]),
      .req_message      (req_tdata[39:8]),
      .csr_we           (csr_valid && csr_ready),
      .csr_value        (csr_data),
      .rsp_status       (status),
      .rsp_received     (received),
      .rsp_pending      (pending),
      .rsp_has_messages (has_messages)
   );

   assign csr_ready = 1'b1;
   assign rsp_tuser = status;
   assign rsp_tdata = {2'b00, has_messages, pending, received};

endmodule

// File: sv/memb_checker.sv
// port-level checker for the multi-endpoint mailbox, with its bind
module memb_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tvalid,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [39:0] rsp_tdata,
   input logic [1:0]  rsp_tuser
);

   // a stalled response item holds its payload
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata) && $stable(rsp_tuser))
      else $error("stalled response changed");

   // only one item in flight: no new item while a response is pending
   assert property (@(posedge clock) disable iff (reset)
      req_tvalid && req_tready |=> !req_tready && !rsp_tvalid)
      else $error("item accepted while busy");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == memb_pkg::ST_INVALID |-> rsp_tdata == '0)
      else $error("invalid endpoint response carries data");

   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && rsp_tuser == memb_pkg::ST_EMPTY |-> rsp_tdata == '0)
      else $error("empty response carries data");

   // a full queue always has messages, and padding bits stay zero
   assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[39:38] == 2'b00 &&
                     (rsp_tuser != memb_pkg::ST_FULL || rsp_tdata[37]))
      else $error("bad response flags");

endmodule

bind multi_endpoint_mailbox memb_checker u_memb_checker (
   .clock      (clock),
   .reset      (reset),
   .req_tvalid (req_tvalid),
   .req_tready (req_tready),
   .rsp_tvalid (rsp_tvalid),
   .rsp_tready (rsp_tready),
   .rsp_tdata  (rsp_tdata),
   .rsp_tuser  (rsp_tuser)
);
